>>> rtl/line_ending_convert_detect_top_assert.svh
// ----------------------------------------------------------------------------
// Line ending converter assertion macros
// Shared assertion forms for the converter modules.
// ----------------------------------------------------------------------------
`ifndef LINE_ENDING_CONVERT_DETECT_TOP_ASSERT_SVH
`define LINE_ENDING_CONVERT_DETECT_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LECD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LECD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lecd_pkg.sv
// ----------------------------------------------------------------------------
// Line ending converter package
// Shared constants and the front-to-back entry format.
// ----------------------------------------------------------------------------
package lecd_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [2:0] STYLE_NONE  = 3'd0;
  localparam logic [2:0] STYLE_LF    = 3'd1;
  localparam logic [2:0] STYLE_CRLF  = 3'd2;
  localparam logic [2:0] STYLE_CR    = 3'd3;
  localparam logic [2:0] STYLE_MIXED = 3'd4;

  localparam logic [1:0] TGT_LF   = 2'd0;
  localparam logic [1:0] TGT_CRLF = 2'd1;
  localparam logic [1:0] TGT_CR   = 2'd2;

  typedef struct packed {
    logic [2:0]  detected_style;
    logic [1:0]  first_style;
    logic [31:0] first_offset;
    logic [1:0]  second_style;
    logic [31:0] second_offset;
    logic [31:0] second_line;
  } report_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            eod;
    report_t         report;
  } entry_t;

endpackage

>>> rtl/lecd_front.sv
// ----------------------------------------------------------------------------
// Line ending converter front end
// Classifies each input byte, tracks style detection and line counts, and
// emits an entry of up to four output bytes for each request that yields output.
// ----------------------------------------------------------------------------
module lecd_front #(
  parameter int COUNT_BITS = lecd_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_wdata,
  input  logic             push,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic             q_full,
  output logic             full,
  output logic             q_push,
  output lecd_pkg::entry_t q_data
);

  localparam int WIDE = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef struct packed {
    logic [2:0]            seen;
    logic [1:0]            fk;
    logic [COUNT_BITS-1:0] fpos;
    logic [1:0]            sk;
    logic [COUNT_BITS-1:0] spos;
    logic [COUNT_BITS-1:0] sline;
    logic [1:0]            linc;
    logic                  after;
  } det_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } ob_t;

  logic [1:0]            target;
  logic                  cr_pending;
  logic [COUNT_BITS-1:0] bp;
  logic [COUNT_BITS-1:0] lc;
  det_t                  det;

  logic [COUNT_BITS-1:0] bp1, bp2, lc1, lc2;
  logic [COUNT_BITS-1:0] bp_next, lc_next, off_cur;
  det_t                  det_next;
  ob_t                   ob;
  logic                  pend_next;
  logic [1:0]            binc;
  logic                  used;
  logic                  accept;

  function automatic logic [31:0] to32(logic [COUNT_BITS-1:0] x);
    logic [WIDE-1:0] w;
    w = WIDE'(x);
    return w[31:0];
  endfunction

  function automatic det_t see_le(det_t d, logic [2:0] kind,
                                  logic [COUNT_BITS-1:0] off,
                                  logic [COUNT_BITS-1:0] c0,
                                  logic [COUNT_BITS-1:0] c1,
                                  logic [COUNT_BITS-1:0] c2);
    det_t r;
    r = d;
    if (d.seen == lecd_pkg::STYLE_NONE) begin
      r.seen = kind;
      r.fk   = kind[1:0];
      r.fpos = off;
    end else begin
      if (d.after) begin
        r.linc = d.linc + 2'd1;
      end
      if (d.seen != lecd_pkg::STYLE_MIXED && d.seen != kind) begin
        r.sk    = kind[1:0];
        r.spos  = off;
        r.sline = (r.linc == 2'd0) ? c0 : ((r.linc == 2'd1) ? c1 : c2);
        r.seen  = lecd_pkg::STYLE_MIXED;
      end
    end
    r.after = 1'b1;
    return r;
  endfunction

  function automatic ob_t put_b(ob_t o, logic [7:0] x);
    ob_t r;
    r = o;
    if (o.n < 3'd4) begin
      r.b[o.n[1:0]] = x;
      r.n = o.n + 3'd1;
    end
    return r;
  endfunction

  function automatic ob_t put_le(ob_t o, logic [1:0] t);
    ob_t r;
    r = o;
    unique case (t)
      lecd_pkg::TGT_CRLF: begin
        r = put_b(r, lecd_pkg::CH_CR);
        r = put_b(r, lecd_pkg::CH_LF);
      end
      lecd_pkg::TGT_CR: r = put_b(r, lecd_pkg::CH_CR);
      default:          r = put_b(r, lecd_pkg::CH_LF);
    endcase
    return r;
  endfunction

  assign bp1 = (bp == CMAX) ? CMAX : bp + COUNT_BITS'(1);
  assign bp2 = (bp >= CMAX - COUNT_BITS'(1)) ? CMAX : bp + COUNT_BITS'(2);
  assign lc1 = (lc == CMAX) ? CMAX : lc + COUNT_BITS'(1);
  assign lc2 = (lc >= CMAX - COUNT_BITS'(1)) ? CMAX : lc + COUNT_BITS'(2);

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    det_next  = det;
    ob        = '0;
    pend_next = 1'b0;
    binc      = 2'd0;
    used      = 1'b0;
    if (cr_pending) begin
      if (in_byte == lecd_pkg::CH_LF) begin
        det_next = see_le(det_next, lecd_pkg::STYLE_CRLF, bp, lc, lc1, lc2);
        ob       = put_le(ob, target);
        binc     = 2'd2;
        used     = 1'b1;
      end else begin
        det_next = see_le(det_next, lecd_pkg::STYLE_CR, bp, lc, lc1, lc2);
        ob       = put_le(ob, target);
        binc     = 2'd1;
      end
    end
    off_cur = (binc == 2'd0) ? bp : bp1;
    if (!used) begin
      if (in_byte == lecd_pkg::CH_LF) begin
        det_next = see_le(det_next, lecd_pkg::STYLE_LF, off_cur, lc, lc1, lc2);
        ob       = put_le(ob, target);
        binc     = binc + 2'd1;
      end else if (in_byte == lecd_pkg::CH_CR) begin
        if (in_last) begin
          det_next = see_le(det_next, lecd_pkg::STYLE_CR, off_cur, lc, lc1, lc2);
          ob       = put_le(ob, target);
          binc     = binc + 2'd1;
        end else begin
          pend_next = 1'b1;
        end
      end else begin
        ob   = put_b(ob, in_byte);
        binc = binc + 2'd1;
        if (det_next.after) begin
          det_next.after = 1'b0;
          det_next.linc  = det_next.linc + 2'd1;
        end
      end
    end
    bp_next = (binc == 2'd0) ? bp : ((binc == 2'd1) ? bp1 : bp2);
    lc_next = (det_next.linc == 2'd0) ? lc : ((det_next.linc == 2'd1) ? lc1 : lc2);
    det_next.linc = 2'd0;
  end

  always_comb begin
    q_push                        = accept && (ob.n != 3'd0);
    q_data.bytes                  = ob.b;
    q_data.last_idx               = 2'(ob.n - 3'd1);
    q_data.eod                    = in_last;
    q_data.report.detected_style  = det_next.seen;
    q_data.report.first_style     = det_next.fk;
    q_data.report.first_offset    = to32(det_next.fpos);
    q_data.report.second_style    = det_next.sk;
    q_data.report.second_offset   = to32(det_next.spos);
    q_data.report.second_line     = to32(det_next.sline);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target     <= lecd_pkg::TGT_LF;
      cr_pending <= 1'b0;
      bp         <= '0;
      lc         <= COUNT_BITS'(1);
      det        <= '0;
    end else begin
      if (cfg_we) begin
        target <= cfg_wdata;
      end
      if (accept) begin
        if (in_last) begin
          cr_pending <= 1'b0;
          bp         <= '0;
          lc         <= COUNT_BITS'(1);
          det        <= '0;
        end else begin
          cr_pending <= pend_next;
          bp         <= bp_next;
          lc         <= lc_next;
          det        <= det_next;
        end
      end
    end
  end

endmodule

>>> rtl/lecd_queue.sv
// ----------------------------------------------------------------------------
// Line ending converter entry queue
// Short FIFO of converted entries between the front and back ends.
// ----------------------------------------------------------------------------
module lecd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  lecd_pkg::entry_t wr_data,
  input  logic             rd_en,
  output lecd_pkg::entry_t rd_data,
  output logic             q_full,
  output logic             q_empty
);

  lecd_pkg::entry_t                 mem [lecd_pkg::QUEUE_DEPTH];
  logic [lecd_pkg::QPTR_W-1:0]      wr_ptr;
  logic [lecd_pkg::QPTR_W-1:0]      rd_ptr;
  logic [lecd_pkg::QCNT_W-1:0]      count;

  assign q_full  = (count == lecd_pkg::QCNT_W'(lecd_pkg::QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == lecd_pkg::QPTR_W'(lecd_pkg::QUEUE_DEPTH - 1)) ? '0 :
                  wr_ptr + lecd_pkg::QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == lecd_pkg::QPTR_W'(lecd_pkg::QUEUE_DEPTH - 1)) ? '0 :
                  rd_ptr + lecd_pkg::QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + lecd_pkg::QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - lecd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/lecd_back.sv
// ----------------------------------------------------------------------------
// Line ending converter back end
// Holds one entry and hands out its bytes, one result per request.
// ----------------------------------------------------------------------------
`include "line_ending_convert_detect_top_assert.svh"

module lecd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  lecd_pkg::entry_t q_data,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             end_of_data,
  output lecd_pkg::report_t report
);

  lecd_pkg::entry_t cur;
  logic             cur_valid;
  logic [1:0]       idx;
  logic             take;
  logic             fin;

  assign take        = pop && cur_valid;
  assign fin         = take && (idx == cur.last_idx);
  assign q_pop       = (!cur_valid || fin) && !q_empty;
  assign empty       = !cur_valid;
  assign out_byte    = cur.bytes[idx];
  assign last_of_run = (idx == cur.last_idx);
  assign end_of_data = last_of_run && cur.eod;
  assign report      = cur.report;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (fin) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  `LECD_ASSERT_NOW(a_idx_range, cur_valid, idx <= cur.last_idx, "byte index past entry")
  `LECD_ASSERT_NEXT(a_drain_empty, fin && q_empty, empty, "stale entry after drain")
  `LECD_ASSERT_NOW(a_mixed_second, cur_valid && (cur.report.detected_style == lecd_pkg::STYLE_MIXED), cur.report.second_style != 2'd0, "mixed without second style")
  `LECD_ASSERT_NOW(a_first_style, cur_valid, (cur.report.detected_style == lecd_pkg::STYLE_NONE) == (cur.report.first_style == 2'd0), "first style disagrees with detection")

endmodule

>>> rtl/line_ending_convert_detect_top.sv
// ----------------------------------------------------------------------------
// Line ending converter and detector, top level
// Rewrites LF, CR LF and lone CR line ends to the configured style and
// reports the detected source style with each output byte.
//
//   channel  handshake        payload
//   input    push / full      in_byte, in_last
//   result   empty / pop      out_byte, last_of_run, end_of_data, report fields
//   config   cfg_we           cfg_wdata (target style)
//
// One input byte per cycle while the entry queue has room; each input yields
// zero to four result bytes, drained one per cycle by the back end while pop
// is asserted. Sustained input rate is bounded by result bytes: a line end
// to CR LF costs two result bytes at the output. Reset is synchronous; no
// clearing pass. full depends only on the queue fill, so a stalled result side
// backs up through the four-entry queue before the input stalls.
// ----------------------------------------------------------------------------
module line_ending_convert_detect_top #(
  parameter int COUNT_BITS = lecd_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        end_of_data,
  output logic [2:0]  detected_style,
  output logic [1:0]  first_style,
  output logic [31:0] first_offset,
  output logic [1:0]  second_style,
  output logic [31:0] second_offset,
  output logic [31:0] second_line
);

  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  lecd_pkg::entry_t  wr_data;
  lecd_pkg::entry_t  rd_data;
  lecd_pkg::report_t report;

  lecd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .push     (push),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .full     (full),
    .q_push   (q_push),
    .q_data   (wr_data)
  );

  lecd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_push),
    .wr_data(wr_data),
    .rd_en  (q_pop),
    .rd_data(rd_data),
    .q_full (q_full),
    .q_empty(q_empty)
  );

  lecd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (rd_data),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .last_of_run(last_of_run),
    .end_of_data(end_of_data),
    .report     (report)
  );

  assign detected_style = report.detected_style;
  assign first_style    = report.first_style;
  assign first_offset   = report.first_offset;
  assign second_style   = report.second_style;
  assign second_offset  = report.second_offset;
  assign second_line    = report.second_line;

endmodule
